[rtl/sst_pkg.sv]
// ----------------------------------------------------------------------------
// sst_pkg
// Types and codes shared by the sorted server table: entry layout, command
// and status codes, controller states and result word.
// ----------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] ip;
    logic [15:0] port;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Command codes on the input word
  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  // Result status codes
  typedef enum logic [2:0] {
    RES_ADDED    = 3'd0,
    RES_PRESENT  = 3'd1,
    RES_CONFLICT = 3'd2,
    RES_FULL     = 3'd3,
    RES_REMOVED  = 3'd4,
    RES_ABSENT   = 3'd5,
    RES_LOCAL    = 3'd6,
    RES_BADIDX   = 3'd7
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_ADD_SHIFT,
    ST_REM_SCAN,
    ST_REM_SHIFT,
    ST_READ,
    ST_DONE
  } state_t;

  // Result word handed from controller to output register
  typedef struct packed {
    status_t status;
    entry_t  entry;
  } result_t;

  // Register index of local_id (paddr[2])
  localparam logic [0:0] REG_LOCAL_ID = 1'b0;

endpackage

`default_nettype wire

[rtl/sorted_server_table_unit.sv]
// Add and remove walk through the entries held via the entry RAM read port, in
//   order; add ends with a final write, and both end in a result stage. Read
//   passes through a read stage first; other commands go straight to the result.
// One word at a time: the next word is accepted once the result has moved
//   to the output register.
// Reset: rst clears count, local_id, FSM and out_valid. Entry RAM is not cleared.
// ----------------------------------------------------------------------------
// sorted_server_table_unit
// Server table kept sorted by ascending id, with add, remove and indexed read
// commands and an APB register for the local node id.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_server_table_unit
  import sst_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // command word
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  command,
  input  wire logic [7:0]  entry_id,
  input  wire logic [31:0] ip_address,
  input  wire logic [15:0] port_number,
  input  wire logic [4:0]  read_index,
  // result word
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [2:0]  status,
  output logic      [7:0]  out_id,
  output logic      [31:0] out_ip,
  output logic      [15:0] out_port,
  output logic      [5:0]  entry_count
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [7:0]         local_id;
  entry_t             in_item;
  result_t            res;
  logic               res_valid, res_ready;
  logic [CNT_W-1:0]   tbl_count;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  // ---- config register ----
  // Only local_id lives at index 0 (paddr[2] clear); paddr[2] set reads as zero.
  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == REG_LOCAL_ID) ? {24'd0, local_id} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_id <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2:2] == REG_LOCAL_ID)) begin
      local_id <= pwdata[7:0];
    end
  end

  // ---- command entry ----
  assign in_item.id   = entry_id;
  assign in_item.ip   = ip_address;
  assign in_item.port = port_number;

  // ---- entry RAM: id, ip, port packed into one word ----
  sst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---- search / shift controller ----
  sst_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .local_id   (local_id),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .in_item    (in_item),
    .read_index (read_index),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .count      (tbl_count),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  // ---- output register ----
  // Holds a finished word so the controller can take the next command.
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status      <= res.status;
      out_id      <= res.entry.id;
      out_ip      <= res.entry.ip;
      out_port    <= res.entry.port;
      entry_count <= 6'(tbl_count);   // count is final by the time the word is ready
    end
  end

`ifndef ASSERT_OFF
  // count never runs past the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(tbl_count) <= CAPACITY)
    else $error("entry count above capacity");

  // count only moves while a command is being worked on
  a_count_busy: assert property (@(posedge clk) disable iff (rst)
    !$stable(tbl_count) |-> !in_ready)
    else $error("entry count changed while idle");

  // a full report always comes with a full table
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == RES_FULL) |-> entry_count == 6'(CAPACITY))
    else $error("full status without full count");

  // entry fields are zero unless a successful read
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != RES_ADDED) |-> (out_id == '0) && (out_ip == '0) && (out_port == '0))
    else $error("entry fields set on non-read status");
`endif

endmodule

`default_nettype wire

[rtl/sst_ram.sv]
// ----------------------------------------------------------------------------
// sst_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/sst_ctrl.sv]
// ----------------------------------------------------------------------------
// sst_ctrl
// Table controller: walks the entry RAM one entry a cycle to search, insert
// with an upward shift, or delete with a downward shift; serves indexed reads and keeps the count.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_ctrl
  import sst_pkg::*;
#(
  parameter int unsigned CAPACITY = 32,
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [7:0]         local_id,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         command,
  input  wire entry_t             in_item,
  input  wire logic [4:0]         read_index,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output result_t                 res,
  output logic      [CNT_W-1:0]   count,
  output logic                    ram_we,
  output logic      [IDX_W-1:0]   ram_waddr,
  output logic      [ENTRY_W-1:0] ram_wdata,
  output logic      [IDX_W-1:0]   ram_raddr,
  input  wire logic [ENTRY_W-1:0] ram_rdata
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  state_t           state, state_next;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] k, k_next;       // index of entry arriving on ram_rdata
  entry_t           carry, carry_next; // entry displaced by the insert
  entry_t           item, item_next;   // latched command entry
  result_t          res_next;

  cmd_t             cmd;
  entry_t           rd_entry;
  logic [CNT_W-1:0] kp1;
  logic             add_full, tbl_empty, is_local, rd_ok;
  logic             key_eq, key_gt, last, at_end, differs;

  assign cmd       = cmd_t'(command);
  assign rd_entry  = entry_t'(ram_rdata);
  assign kp1       = k + 1'b1;
  assign add_full  = (count >= CAP_CNT);
  assign tbl_empty = (count == '0);
  assign is_local  = (in_item.id == local_id);
  assign rd_ok     = (32'(read_index) < 32'(count)) && (32'(read_index) < CAPACITY);
  assign key_eq    = (rd_entry.id == item.id);
  assign key_gt    = (rd_entry.id > item.id);
  assign last      = (kp1 == count);
  assign at_end    = (k == count);
  assign differs   = (rd_entry.ip != item.ip) || (rd_entry.port != item.port);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (cmd)
            CMD_ADD: begin
              if (add_full) begin
                state_next = ST_DONE;
              end else if (tbl_empty) begin
                state_next = ST_ADD_SHIFT;
              end else begin
                state_next = ST_ADD_SCAN;
              end
            end
            CMD_REMOVE: begin
              if (is_local || tbl_empty) begin
                state_next = ST_DONE;
              end else begin
                state_next = ST_REM_SCAN;
              end
            end
            CMD_READ: begin
              state_next = rd_ok ? ST_READ : ST_DONE;
            end
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_ADD_SCAN: begin
        if (key_eq) begin
          state_next = ST_DONE;
        end else if (key_gt || last) begin
          state_next = ST_ADD_SHIFT;
        end
      end
      ST_ADD_SHIFT: begin
        if (at_end) begin
          state_next = ST_DONE;
        end
      end
      ST_REM_SCAN: begin
        if (key_eq) begin
          state_next = ST_REM_SHIFT;
        end else if (key_gt || last) begin
          state_next = ST_DONE;
        end
      end
      ST_REM_SHIFT: begin
        if (at_end) begin
          state_next = ST_DONE;
        end
      end
      ST_READ: state_next = ST_DONE;
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = k[IDX_W-1:0];
    ram_wdata  = carry;
    ram_raddr  = kp1[IDX_W-1:0];
    count_next = count;
    k_next     = k;
    carry_next = carry;
    item_next  = item;
    res_next   = res;
    unique case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        ram_raddr  = (cmd == CMD_READ) ? IDX_W'(read_index) : '0;
        k_next     = '0;
        carry_next = in_item;
        item_next  = in_item;
        res_next   = '{status: RES_BADIDX, entry: '0};
        unique case (cmd)
          CMD_ADD:    res_next.status = RES_FULL;
          CMD_REMOVE: res_next.status = is_local ? RES_LOCAL : RES_ABSENT;
          CMD_READ:   res_next.status = RES_BADIDX;
          default:    res_next.status = RES_BADIDX;
        endcase
      end
      ST_ADD_SCAN: begin
        k_next = kp1;
        if (key_eq) begin
          res_next.status = differs ? RES_CONFLICT : RES_PRESENT;
        end else if (key_gt) begin
          // insert here, hold the displaced entry for the shift
          ram_we     = 1'b1;
          ram_wdata  = item;
          carry_next = rd_entry;
        end
      end
      ST_ADD_SHIFT: begin
        ram_we = 1'b1;
        if (at_end) begin
          count_next      = count + 1'b1;
          res_next.status = RES_ADDED;
        end else begin
          carry_next = rd_entry;
          k_next     = kp1;
        end
      end
      ST_REM_SCAN: begin
        k_next = kp1;
      end
      ST_REM_SHIFT: begin
        if (at_end) begin
          count_next      = count - 1'b1;
          res_next.status = RES_REMOVED;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = IDX_W'(k - 1'b1);
          ram_wdata = rd_entry;
          k_next    = kp1;
        end
      end
      ST_READ: begin
        res_next = '{status: RES_ADDED, entry: rd_entry};
      end
      ST_DONE: begin
        res_valid = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    k     <= k_next;
    carry <= carry_next;
    item  <= item_next;
    res   <= res_next;
  end

endmodule

`default_nettype wire
